@@ hw/rtl/scd_pkg.sv @@
// shared types and constants for the signed constant divider
`default_nettype none
package scd_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned DivW   = 63;
  localparam int unsigned ShiftW = 6;
  localparam int unsigned HalfW  = 32;

  localparam logic [DataW-1:0]  SignBit      = 64'h8000_0000_0000_0000;
  localparam logic [DataW-1:0]  MaxPos       = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DataW-1:0]  ResetMagic   = 64'h8000_0000_0000_0001;
  localparam logic [ShiftW-1:0] ResetShift   = 6'd0;
  localparam logic [DivW-1:0]   ResetDivisor = 63'd2;
  localparam logic [6:0]        GuardLimit   = 7'd64;

  typedef enum logic [1:0] {
    MG_IDLE,
    MG_DIV_D,
    MG_DIV_ANC,
    MG_LOOP
  } mg_state_e;

  typedef enum logic {
    OP_QUOT = 1'b0,
    OP_REM  = 1'b1
  } op_e;

  typedef struct packed {
    logic              busy;
    logic [DataW-1:0]  mult;
    logic [ShiftW-1:0] shift;
    logic [DivW-1:0]   divisor;
  } magic_t;

endpackage
`default_nettype wire

@@ hw/rtl/scd_if.sv @@
// item channel interfaces for the signed constant divider
`default_nettype none
interface scd_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [63:0] dividend;
  logic               narrow_mode;
  modport source (output valid, opcode, dividend, narrow_mode, input ready);
  modport sink (input valid, opcode, dividend, narrow_mode, output ready);
endinterface

interface scd_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result_value;
  modport source (output valid, result_value, input ready);
  modport sink (input valid, result_value, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/signed_constant_divider.sv @@
// top level of the signed constant divider
//
//  channel     dir  handshake        payload
//  item_in_i   in   valid/ready      opcode, dividend, narrow_mode
//  item_out_o  out  valid/ready      result_value
//  cfg         in   cfg_we_i         cfg_wdata_i (divisor)
//
// one item per cycle while item_out_o is ready and no derivation runs
// a divisor write runs the magic derivation: bit-serial division of 2^63 by
// the divisor, then by anc, then refinement steps, item_in_i.ready low meanwhile
// reset loads the magic values for divisor two, no derivation needed
// a stall holds every stage that has no free slot ahead of it
`default_nettype none
module signed_constant_divider (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [scd_pkg::DivW-1:0] cfg_wdata_i,
  scd_in_if.sink                        item_in_i,
  scd_out_if.source                     item_out_o
);

  scd_pkg::magic_t magic;

  scd_magic u_magic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .magic_o     (magic)
  );

  scd_pipe u_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .magic_i  (magic),
    .item_in  (item_in_i),
    .item_out (item_out_o)
  );

endmodule
`default_nettype wire

@@ hw/rtl/scd_magic.sv @@
// magic multiplier and shift derivation sequencer
`default_nettype none
module scd_magic (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [scd_pkg::DivW-1:0]   cfg_wdata_i,
  output scd_pkg::magic_t                 magic_o
);

  scd_pkg::mg_state_e state_q, state_d;

  logic [scd_pkg::DivW-1:0]   divisor_q;
  logic [scd_pkg::DataW-1:0]  mult_q;
  logic [scd_pkg::ShiftW-1:0] shift_q;
  logic [5:0]                 cnt_q;
  logic [scd_pkg::DataW-1:0]  rem_q, quo_q;
  logic [scd_pkg::DataW-1:0]  anc_q, q1_q, r1_q, q2_q, r2_q;
  logic [6:0]                 guard_q;
  logic [scd_pkg::ShiftW-1:0] sh_q;

  logic [scd_pkg::DataW-1:0]  d_ext, x_op, rem_sh, rem_nx, quo_nx;
  logic                       ge;
  logic [scd_pkg::DataW-1:0]  q1_n, r1_n, q2_n, r2_n, delta;
  logic [6:0]                 guard_n;
  logic [scd_pkg::ShiftW-1:0] sh_n;
  logic                       cont;
  logic [scd_pkg::DivW-1:0]   wdata_sat;

  assign d_ext     = {1'b0, divisor_q};
  assign wdata_sat = (cfg_wdata_i < scd_pkg::ResetDivisor) ? scd_pkg::ResetDivisor : cfg_wdata_i;

  // one restoring step of 2^63 divided by the current operand
  always_comb begin
    x_op   = (state_q == scd_pkg::MG_DIV_ANC) ? anc_q : d_ext;
    rem_sh = {rem_q[scd_pkg::DataW-2:0], (cnt_q == 6'd63)};
    ge     = (rem_sh >= x_op);
    rem_nx = ge ? (rem_sh - x_op) : rem_sh;
    quo_nx = {quo_q[scd_pkg::DataW-2:0], ge};
  end

  // one refinement iteration
  always_comb begin
    q1_n = {q1_q[scd_pkg::DataW-2:0], 1'b0};
    r1_n = {r1_q[scd_pkg::DataW-2:0], 1'b0};
    if (r1_n >= anc_q) begin
      q1_n = q1_n + 64'd1;
      r1_n = r1_n - anc_q;
    end
    q2_n = {q2_q[scd_pkg::DataW-2:0], 1'b0};
    r2_n = {r2_q[scd_pkg::DataW-2:0], 1'b0};
    if (r2_n >= d_ext) begin
      q2_n = q2_n + 64'd1;
      r2_n = r2_n - d_ext;
    end
    delta   = d_ext - r2_n;
    guard_n = guard_q + 7'd1;
    sh_n    = sh_q + 6'd1;
    cont    = ((q1_n < delta) || ((q1_n == delta) && (r1_n == '0))) &&
              (guard_n < scd_pkg::GuardLimit);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      scd_pkg::MG_IDLE:    if (cfg_we_i) state_d = scd_pkg::MG_DIV_D;
      scd_pkg::MG_DIV_D:   if (cnt_q == '0) state_d = scd_pkg::MG_DIV_ANC;
      scd_pkg::MG_DIV_ANC: if (cnt_q == '0) state_d = scd_pkg::MG_LOOP;
      scd_pkg::MG_LOOP:    if (!cont) state_d = scd_pkg::MG_IDLE;
      default:             state_d = scd_pkg::MG_IDLE;
    endcase
  end

  always_comb begin
    magic_o.busy    = (state_q != scd_pkg::MG_IDLE);
    magic_o.mult    = mult_q;
    magic_o.shift   = shift_q;
    magic_o.divisor = divisor_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= scd_pkg::MG_IDLE;
      divisor_q <= scd_pkg::ResetDivisor;
      mult_q    <= scd_pkg::ResetMagic;
      shift_q   <= scd_pkg::ResetShift;
      cnt_q     <= 6'd63;
      guard_q   <= '0;
      sh_q      <= '1;
    end else begin
      state_q <= state_d;
      case (state_q)
        scd_pkg::MG_IDLE: begin
          if (cfg_we_i) begin
            divisor_q <= wdata_sat;
            cnt_q     <= 6'd63;
          end
        end
        scd_pkg::MG_DIV_D, scd_pkg::MG_DIV_ANC: begin
          cnt_q <= cnt_q - 6'd1;
        end
        scd_pkg::MG_LOOP: begin
          guard_q <= guard_n;
          sh_q    <= sh_n;
          if (!cont) begin
            mult_q  <= q2_n + 64'd1;
            shift_q <= sh_n;
          end
        end
        default: cnt_q <= 6'd63;
      endcase
      if (state_q == scd_pkg::MG_DIV_ANC && cnt_q == '0) begin
        guard_q <= '0;
        sh_q    <= '1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      scd_pkg::MG_IDLE: begin
        rem_q <= '0;
        quo_q <= '0;
      end
      scd_pkg::MG_DIV_D: begin
        if (cnt_q == '0) begin
          q2_q  <= quo_nx;
          r2_q  <= rem_nx;
          anc_q <= scd_pkg::MaxPos - rem_nx;
          rem_q <= '0;
          quo_q <= '0;
        end else begin
          rem_q <= rem_nx;
          quo_q <= quo_nx;
        end
      end
      scd_pkg::MG_DIV_ANC: begin
        rem_q <= rem_nx;
        quo_q <= quo_nx;
        if (cnt_q == '0) begin
          q1_q <= quo_nx;
          r1_q <= rem_nx;
        end
      end
      scd_pkg::MG_LOOP: begin
        q1_q <= q1_n;
        r1_q <= r1_n;
        q2_q <= q2_n;
        r2_q <= r2_n;
      end
      default: begin
        rem_q <= '0;
        quo_q <= '0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/scd_pipe.sv @@
// six stage multiply, shift and remainder pipeline
`default_nettype none
module scd_pipe (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire scd_pkg::magic_t magic_i,
  scd_in_if.sink          item_in,
  scd_out_if.source       item_out
);

  localparam int unsigned W = scd_pkg::DataW;
  localparam int unsigned H = scd_pkg::HalfW;

  logic [6:1] v_q;
  logic [6:1] adv;

  // payload carried along
  logic [W-1:0] n1_q, n2_q, n3_q, n4_q, n5_q;
  logic [5:1]   op_q, nar_q;
  logic         neg1_q, neg2_q;

  logic [W-1:0] ll_q, lh_q, hl_q, hh_q;
  logic [H+1:0] mid_q;
  logic [W-1:0] hsum_q, h_q, q4_q, q5_q;
  logic [W-1:0] pll_q;
  logic [H-1:0] plh_q, phl_q;
  logic [W-1:0] res_q;

  logic [W-1:0] n_in, m;
  logic [W-1:0] h_nx, sh_nx, prod, rem;
  logic [W-1:0] sel, res_nx;

  assign n_in = item_in.dividend;
  assign m    = magic_i.mult;

  always_comb begin
    adv[6] = !v_q[6] || item_out.ready;
    for (int k = 5; k >= 1; k--) adv[k] = !v_q[k] || adv[k+1];
  end

  assign item_in.ready = adv[1] && !magic_i.busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[1]) v_q[1] <= item_in.valid && !magic_i.busy;
      for (int k = 2; k <= 6; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_comb begin
    h_nx   = hsum_q + {{(W-2){1'b0}}, mid_q[H+1:H]} - (neg2_q ? m : '0);
    sh_nx  = W'($signed(h_q) >>> magic_i.shift);
    prod   = pll_q + {plh_q + phl_q, {H{1'b0}}};
    rem    = n5_q - prod;
    sel    = (op_q[5] == scd_pkg::OP_REM) ? rem : q5_q;
    res_nx = nar_q[5] ? {{H{sel[H-1]}}, sel[H-1:0]} : sel;
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      n1_q    <= n_in;
      op_q[1] <= item_in.opcode;
      nar_q[1] <= item_in.narrow_mode;
      neg1_q  <= n_in[W-1];
      ll_q    <= n_in[H-1:0] * m[H-1:0];
      lh_q    <= n_in[H-1:0] * m[W-1:H];
      hl_q    <= n_in[W-1:H] * m[H-1:0];
      hh_q    <= n_in[W-1:H] * m[W-1:H];
    end
    if (adv[2]) begin
      n2_q     <= n1_q;
      op_q[2]  <= op_q[1];
      nar_q[2] <= nar_q[1];
      neg2_q   <= neg1_q;
      mid_q    <= {2'b00, ll_q[W-1:H]} + {2'b00, lh_q[H-1:0]} + {2'b00, hl_q[H-1:0]};
      hsum_q   <= hh_q + {{H{1'b0}}, lh_q[W-1:H]} + {{H{1'b0}}, hl_q[W-1:H]};
    end
    if (adv[3]) begin
      n3_q     <= n2_q;
      op_q[3]  <= op_q[2];
      nar_q[3] <= nar_q[2];
      h_q      <= h_nx;
    end
    if (adv[4]) begin
      n4_q     <= n3_q;
      op_q[4]  <= op_q[3];
      nar_q[4] <= nar_q[3];
      q4_q     <= sh_nx + {{(W-1){1'b0}}, sh_nx[W-1]};
    end
    if (adv[5]) begin
      n5_q     <= n4_q;
      op_q[5]  <= op_q[4];
      nar_q[5] <= nar_q[4];
      q5_q     <= q4_q;
      pll_q    <= q4_q[H-1:0] * {1'b0, magic_i.divisor[H-1:0]};
      plh_q    <= H'(q4_q[H-1:0] * {1'b0, magic_i.divisor[scd_pkg::DivW-1:H]});
      phl_q    <= H'(q4_q[W-1:H] * magic_i.divisor[H-1:0]);
    end
    if (adv[6]) begin
      res_q <= res_nx;
    end
  end

  assign item_out.valid        = v_q[6];
  assign item_out.result_value = res_q;

endmodule
`default_nettype wire

@@ sim/scd_checker.sv @@
// checker for the signed constant divider: predicts each quotient or remainder and compares
module scd_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [scd_pkg::DivW-1:0]   cfg_wdata_i,
  scd_in_if                          in_ch,
  scd_out_if                         out_ch,
  output int                         mismatch_count_o,
  output int                         pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [scd_pkg::DataW-1:0]  divisor_q;
  logic [scd_pkg::DataW-1:0]  mult_q;
  logic [scd_pkg::ShiftW-1:0] shift_q;
  logic [scd_pkg::DataW-1:0]  pending_results[$];

  function automatic void derive_magic(input logic [scd_pkg::DataW-1:0] d,
                                       output logic [scd_pkg::DataW-1:0] mult,
                                       output logic [scd_pkg::ShiftW-1:0] shift);
    logic [scd_pkg::DataW-1:0] t, anc, p, q1, r1, q2, r2, delta;
    int guard;
    t = scd_pkg::SignBit;
    anc = t - 1 - t % d;
    p = 63;
    q1 = t / anc;
    r1 = t - q1 * anc;
    q2 = t / d;
    r2 = t - q2 * d;
    guard = 0;
    do begin
      p++;
      q1 = q1 << 1;
      r1 = r1 << 1;
      if (r1 >= anc) begin
        q1++;
        r1 = r1 - anc;
      end
      q2 = q2 << 1;
      r2 = r2 << 1;
      if (r2 >= d) begin
        q2++;
        r2 = r2 - d;
      end
      delta = d - r2;
      guard++;
    end while ((q1 < delta || (q1 == delta && r1 == 0)) && guard < 64);
    mult = q2 + 1;
    shift = scd_pkg::ShiftW'(p - 64);
  endfunction

  function automatic logic [scd_pkg::DataW-1:0] divide_item(
      input scd_pkg::op_e op,
      input logic [scd_pkg::DataW-1:0] n,
      input logic narrow);
    logic signed [2*scd_pkg::DataW-1:0] prod;
    logic [scd_pkg::DataW-1:0] q, r;
    prod = $signed({{scd_pkg::DataW{n[scd_pkg::DataW-1]}}, n}) *
           $signed({{scd_pkg::DataW{mult_q[scd_pkg::DataW-1]}}, mult_q});
    q = prod[2*scd_pkg::DataW-1:scd_pkg::DataW];
    if (mult_q[scd_pkg::DataW-1]) q = q + n;
    q = $signed(q) >>> shift_q;
    q = q + {63'd0, q[scd_pkg::DataW-1]};
    r = (op == scd_pkg::OP_REM) ? n - q * divisor_q : q;
    if (narrow) r = {{scd_pkg::HalfW{r[scd_pkg::HalfW-1]}}, r[scd_pkg::HalfW-1:0]};
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [scd_pkg::DataW-1:0] want, d;
    logic [scd_pkg::DataW-1:0] m;
    logic [scd_pkg::ShiftW-1:0] s;
    if (!rst_ni) begin
      divisor_q <= 64'(scd_pkg::ResetDivisor);
      mult_q <= scd_pkg::ResetMagic;
      shift_q <= scd_pkg::ResetShift;
      pending_results.delete();
      mismatch_count_o <= 0;
      pending_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        d = {1'b0, cfg_wdata_i};
        if (d < 2) d = 2;
        derive_magic(d, m, s);
        divisor_q <= d;
        mult_q <= m;
        shift_q <= s;
      end
      if (in_ch.valid && in_ch.ready)
        pending_results.push_back(divide_item(scd_pkg::op_e'(in_ch.opcode), in_ch.dividend,
                                              in_ch.narrow_mode));
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%t unexpected result: expected none, actual %h", $time,
                   out_ch.result_value);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = pending_results.pop_front();
          if (want !== out_ch.result_value) begin
            $display("%t result_value mismatch: expected %h, actual %h", $time, want,
                     out_ch.result_value);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      pending_count_o <= pending_results.size();
    end
  end

endmodule

@@ sim/testbench.sv @@
// top of the signed constant divider testbench: stimulus, idling phases and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [scd_pkg::DivW-1:0] cfg_wdata_i = '0;
  int                       mismatch_count;
  int                       pending_count;
  int                       send_idle_pct = 0;
  int                       recv_stall_pct = 0;

  scd_in_if  in_ch ();
  scd_out_if out_ch ();

  signed_constant_divider i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_in_i  (in_ch),
    .item_out_o (out_ch)
  );

  scd_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = 1'b0;
    in_ch.dividend = '0;
    in_ch.narrow_mode = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_item(input scd_pkg::op_e op, input logic [scd_pkg::DataW-1:0] n,
                           input logic narrow);
    int gap;
    logic took;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.dividend <= n;
    in_ch.narrow_mode <= narrow;
    do begin
      @(negedge clk_i);
      took = in_ch.ready;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic drain;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  task automatic write_divisor(input logic [scd_pkg::DivW-1:0] v);
    in_ch.valid <= 1'b0;
    drain();
    repeat (12) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [scd_pkg::DataW-1:0] pick_dividend(
      input logic [scd_pkg::DivW-1:0] dv);
    logic [scd_pkg::DataW-1:0] d, k;
    d = {1'b0, dv};
    k = {$urandom, $urandom};
    case ($urandom_range(5))
      0, 1: return {$urandom, $urandom};
      2: return scd_pkg::DataW'($signed($urandom_range(2000)) - 1000);
      3: return k % 4096 * d + scd_pkg::DataW'($signed($urandom_range(6)) - 3);
      4: return -(k % 4096 * d) + scd_pkg::DataW'($signed($urandom_range(6)) - 3);
      default: return $urandom_range(1) ? scd_pkg::SignBit + $urandom_range(3)
                                        : scd_pkg::MaxPos - $urandom_range(3);
    endcase
  endfunction

  function automatic logic [scd_pkg::DivW-1:0] pick_divisor();
    case ($urandom_range(3))
      0: return scd_pkg::DivW'($urandom_range(2, 40));
      1: return scd_pkg::DivW'(1) << $urandom_range(62);
      2: return scd_pkg::DivW'({$urandom, $urandom});
      default: return scd_pkg::DivW'($urandom);
    endcase
  endfunction

  initial begin
    logic [scd_pkg::DivW-1:0] dv;
    logic [scd_pkg::DataW-1:0] edge_vals[6];
    edge_vals = '{scd_pkg::SignBit, scd_pkg::MaxPos, 64'd0, '1, 64'd1, scd_pkg::SignBit + 1};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset divisor, extremes, both operations and widths, then divisors 0, 1, all ones and 7
    foreach (edge_vals[i]) begin
      send_item(scd_pkg::OP_QUOT, edge_vals[i], 1'b0);
      send_item(scd_pkg::OP_REM, edge_vals[i], 1'b1);
    end
    write_divisor('0);
    send_item(scd_pkg::OP_QUOT, scd_pkg::SignBit, 1'b0);
    send_item(scd_pkg::OP_REM, 64'd7, 1'b0);
    write_divisor(scd_pkg::DivW'(1));
    send_item(scd_pkg::OP_REM, 64'hFFFF_FFFF_8000_0001, 1'b1);
    write_divisor('1);
    foreach (edge_vals[i]) send_item(scd_pkg::op_e'(i % 2), edge_vals[i], 1'b0);
    write_divisor(scd_pkg::DivW'(7));
    send_item(scd_pkg::OP_QUOT, -64'sd7, 1'b0);
    send_item(scd_pkg::OP_REM, -64'sd13, 1'b0);
    send_item(scd_pkg::OP_QUOT, scd_pkg::SignBit, 1'b1);

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      dv = (ph == 3) ? '1 : (ph == 7) ? scd_pkg::DivW'(2) : pick_divisor();
      write_divisor(dv);
      for (int i = 0; i < 106; i++) begin
        if (ph == 5 && i == 50) begin
          in_ch.valid <= 1'b0;
          drain();
        end
        send_item(scd_pkg::op_e'($urandom_range(1)), pick_dividend(dv),
                  1'($urandom_range(1)));
      end
    end
    in_ch.valid <= 1'b0;
    recv_stall_pct = 0;
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
